// ===== hdl/ntc_pkg.sv =====
// ntc_pkg: shared types and constants for the NTC table interpolator.
// Holds request/result payloads, table entry, divider and sequencer types.
// No dependencies.
package ntc_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam int DIV_STEPS = 16;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic       FUNC_LOAD    = 1'b0;
    localparam logic       FUNC_CONVERT = 1'b1;
    localparam logic [15:0] OOR_TEMP    = 16'hFFFF;

    typedef struct packed {
        logic        func;
        logic [4:0]  entry_index;
        logic [15:0] entry_code;
        logic [15:0] entry_temp;
        logic [11:0] adc_code;
        logic [1:0]  channel;
    } req_t;

    typedef struct packed {
        logic [15:0] temperature;
        logic [1:0]  channel_out;
        logic        out_of_range;
    } res_t;

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] temp;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_DIVIDE,
        ST_MUL,
        ST_SUB,
        ST_DONE
    } seq_state_t;

endpackage

// ===== hdl/ntc_table_mem.sv =====
// ntc_table_mem: breakpoint table storage, one write and one registered read port.
// Depends on ntc_pkg (entry_t, TABLE_DEPTH, TABLE_AW).
module ntc_table_mem
    import ntc_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [TABLE_AW-1:0] wr_addr,
    input  entry_t              wr_data,
    input  logic [TABLE_AW-1:0] rd_addr,
    output entry_t              rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ntc_div.sv =====
// ntc_div: 16-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on ntc_pkg (div_req_t, div_rsp_t, DIV_STEPS).
module ntc_div
    import ntc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [15:0]       rem_reg, rem_next;
    logic [15:0]       quo_reg, quo_next;
    logic [15:0]       dvs_reg, dvs_next;
    logic [16:0]       shifted;
    logic [16:0]       trial;
    logic              fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[15]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            rem_next = fits ? trial[15:0] : shifted[15:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg + DIV_CW'(1);
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/ntc_table_interpolator.sv =====
// ntc_table_interpolator: top level, sequencer around the table memory and divider.
// Depends on ntc_pkg, ntc_table_mem, ntc_div.
//
// Usage: one request channel (req_valid / req_stall / req_data) and one result
// channel (res_valid / res_stall / res_data). A request is taken at a clock edge
// with valid high and stall low.
//  - Load request (func = 0): writes one (code, temperature) entry of the
//    breakpoint table in the accepting cycle. No result. The block stays ready,
//    so loads can stream one per cycle. Indexes beyond the table are dropped.
//  - Convert request (func = 1): walks the table from entry 1, one entry per
//    cycle through the memory read port, until the first code below the sample.
//    The slope is found by the 16-step serial divider, then one 16x16 multiply
//    and one subtract give the temperature. req_stall stays high until the
//    result is in the output register; the next request is taken the cycle after.
//  - The result sits in an output register; if the receiver stalls, a finished
//    conversion waits in the sequencer until the register frees up.
// Reset (rst_n low) clears the sequencer and the result valid; the table is
// not cleared and must be fully loaded, end marker included, before converting.
module ntc_table_interpolator
    import ntc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    seq_state_t          state_reg, state_next;
    logic [TABLE_AW-1:0] k_reg, k_next;
    entry_t              prev_reg, prev_next;
    logic [11:0]         sample_reg, sample_next;
    logic [1:0]          chan_reg, chan_next;
    logic                neg_reg, neg_next;
    logic [15:0]         diff_reg, diff_next;
    logic [15:0]         slope_reg, slope_next;
    logic [15:0]         prod_reg, prod_next;
    logic [15:0]         temp_reg, temp_next;
    logic                oor_reg, oor_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_data_reg, res_data_next;

    logic                accept;
    logic                wr_en;
    logic [TABLE_AW-1:0] rd_addr;
    entry_t              cur;
    entry_t              wr_entry;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // signed steps between previous and current breakpoint, and their magnitudes
    logic [16:0]         tstep;
    logic [16:0]         cstep;
    logic [16:0]         tmag;
    logic [16:0]         cmag;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);

    assign wr_en = accept && (req_data.func == FUNC_LOAD)
                   && (32'(req_data.entry_index) < TABLE_DEPTH);
    assign wr_entry.code = req_data.entry_code;
    assign wr_entry.temp = req_data.entry_temp;

    ntc_table_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (TABLE_AW'(req_data.entry_index)),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (cur)
    );

    ntc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign tstep = {1'b0, prev_reg.temp} - {1'b0, cur.temp};
    assign cstep = {1'b0, prev_reg.code} - {1'b0, cur.code};
    assign tmag  = tstep[16] ? (17'd0 - tstep) : tstep;
    assign cmag  = cstep[16] ? (17'd0 - cstep) : cstep;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        sample_next    = sample_reg;
        chan_next      = chan_reg;
        neg_next       = neg_reg;
        diff_next      = diff_reg;
        slope_next     = slope_reg;
        prod_next      = prod_reg;
        temp_next      = temp_reg;
        oor_next       = oor_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        rd_addr        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = tmag[15:0];
        div_req.divisor  = cmag[15:0];

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // entry 0 is read every idle cycle, ready for PRIME
                rd_addr = '0;
                if (accept && (req_data.func == FUNC_CONVERT))
                begin
                    sample_next = req_data.adc_code;
                    chan_next   = req_data.channel;
                    k_next      = TABLE_AW'(1);
                    state_next  = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                prev_next  = cur;
                rd_addr    = k_reg;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                rd_addr = k_reg + TABLE_AW'(1);
                if (cur.code == 16'd0)
                begin
                    temp_next  = OOR_TEMP;
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if ({4'd0, sample_reg} > cur.code)
                begin
                    if (cstep == 17'd0)
                    begin
                        temp_next  = OOR_TEMP;
                        oor_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        neg_next      = tstep[16] ^ cstep[16];
                        diff_next     = prev_reg.code - {4'd0, sample_reg};
                        state_next    = ST_DIVIDE;
                    end
                end
                else if (k_reg == TABLE_AW'(TABLE_DEPTH - 1))
                begin
                    temp_next  = OOR_TEMP;
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    prev_next = cur;
                    k_next    = k_reg + TABLE_AW'(1);
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    // truncation toward zero: negate the magnitude quotient
                    slope_next = neg_reg ? (16'd0 - div_rsp.quotient) : div_rsp.quotient;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = 16'(slope_reg * diff_reg);
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                temp_next  = prev_reg.temp - prod_reg;
                oor_next   = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next             = 1'b1;
                    res_data_next.temperature  = temp_reg;
                    res_data_next.channel_out  = chan_reg;
                    res_data_next.out_of_range = oor_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        sample_reg   <= sample_next;
        chan_reg     <= chan_next;
        neg_reg      <= neg_next;
        diff_reg     <= diff_next;
        slope_reg    <= slope_next;
        prod_reg     <= prod_next;
        temp_reg     <= temp_next;
        oor_reg      <= oor_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== hdl/ntc_checker.sv =====
// ntc_checker: port-level assertions for ntc_table_interpolator, bound to the top.
// Depends on ntc_pkg and ntc_table_interpolator.
module ntc_checker
    import ntc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req_data,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // a convert request makes the block busy
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.func == FUNC_CONVERT) |=> req_stall)
        else $error("not busy after convert request");

    // a load request leaves the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.func == FUNC_LOAD) |=> !req_stall)
        else $error("stalled after load request");

    // out of range always carries the marker value
    a_oor_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.out_of_range |-> res_data.temperature == OOR_TEMP)
        else $error("out of range without marker temperature");

endmodule

bind ntc_table_interpolator ntc_checker u_ntc_checker (.*);

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for ntc_table_interpolator.
// Loads breakpoint tables and converts samples under changing stall patterns. Each result
// is checked against a table walk kept in the testbench. Depends on ntc_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ntc_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req_data  = '0;
    logic req_stall;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    // Breakpoint table as seen by accepted load requests, in acceptance order.
    logic [15:0] bp_code [TABLE_DEPTH];
    logic [15:0] bp_temp [TABLE_DEPTH];

    // Expected conversion results, oldest first.
    res_t temps_due [$];

    int mismatch_count = 0;

    // Idle rates in percent: sender gaps and receiver stalls.
    int send_idle_pct = 0;
    int res_stall_pct = 0;

    // Long receiver hold-off: the test raises hold_target, the counter below catches up.
    int  hold_target = 0;
    int  hold_done   = 0;
    wire hold_active = (hold_done != hold_target);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog, sized from the slowest legal run with a wide margin.
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    ntc_table_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Behavioral table walk: first entry from 1 whose code lies below the sample,
    // slope truncated toward zero, result kept to 16 bits.
    function automatic res_t predict_conversion(logic [11:0] sample, logic [1:0] chan);
        res_t   r;
        longint smp;
        longint prev_code;
        longint prev_temp;
        longint cur_code;
        longint cur_temp;
        longint code_step;
        longint slope;
        longint value;
        r.temperature  = OOR_TEMP;
        r.channel_out  = chan;
        r.out_of_range = 1'b1;
        smp = sample;
        for (int k = 1; k < TABLE_DEPTH; k++)
        begin
            if (bp_code[k] == 16'd0)
                break;
            if (sample > bp_code[k])
            begin
                prev_code = bp_code[k-1];
                prev_temp = bp_temp[k-1];
                cur_code  = bp_code[k];
                cur_temp  = bp_temp[k];
                code_step = prev_code - cur_code;
                // equal codes on both sides of the step: flagged, not divided
                if (code_step != 0)
                begin
                    slope = (prev_temp - cur_temp) / code_step;
                    value = prev_temp - slope * (prev_code - smp);
                    r.temperature  = value[15:0];
                    r.out_of_range = 1'b0;
                end
                break;
            end
        end
        return r;
    endfunction

    // Unused fields of each request carry random bits; the block must ignore them.
    function automatic req_t load_req(int idx, int code, int temp);
        req_t r;
        r.func        = FUNC_LOAD;
        r.entry_index = 5'(idx);
        r.entry_code  = 16'(code);
        r.entry_temp  = 16'(temp);
        r.adc_code    = 12'($urandom_range(4095));
        r.channel     = 2'($urandom_range(3));
        return r;
    endfunction

    function automatic req_t convert_req(int sample, int chan);
        req_t r;
        r.func        = FUNC_CONVERT;
        r.entry_index = 5'($urandom_range(31));
        r.entry_code  = 16'($urandom_range(65535));
        r.entry_temp  = 16'($urandom_range(65535));
        r.adc_code    = 12'(sample);
        r.channel     = 2'(chan);
        return r;
    endfunction

    // Offer one request and hold it until accepted. Valid stays high on return so
    // back-to-back requests need no gap; wait_drain lowers it.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        if (r.func == FUNC_LOAD)
        begin
            if (r.entry_index < TABLE_DEPTH)
            begin
                bp_code[r.entry_index] = r.entry_code;
                bp_temp[r.entry_index] = r.entry_temp;
            end
        end
        else
            temps_due.push_back(predict_conversion(r.adc_code, r.channel));
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (temps_due.size() != 0);
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (temps_due.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: temp %h chan %0d oor %0b",
                                      got.temperature, got.channel_out, got.out_of_range));
        end
        else
        begin
            want = temps_due.pop_front();
            if (got.temperature !== want.temperature)
                report_mismatch($sformatf("temperature %h, expected %h",
                                          got.temperature, want.temperature));
            if (got.channel_out !== want.channel_out)
                report_mismatch($sformatf("channel_out %0d, expected %0d",
                                          got.channel_out, want.channel_out));
            if (got.out_of_range !== want.out_of_range)
                report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                          got.out_of_range, want.out_of_range));
        end
    endtask

    // Receiver: check on every accepted result, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            check_result(res_data);
        res_stall <= hold_active || ($urandom_range(99) < res_stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_done != hold_target)
            hold_done <= hold_done + 1;
    end

    // Sample choice: the extremes, codes at or next to a breakpoint, or anything.
    function automatic int pick_sample();
        int c;
        case ($urandom_range(9))
            0: c = 0;
            1: c = 4095;
            2, 3, 4, 5:
            begin
                c = int'(bp_code[$urandom_range(TABLE_DEPTH - 1)]) + $urandom_range(2) - 1;
                if (c < 0)
                    c = 0;
                if (c > 4095)
                    c = $urandom_range(4095);
            end
            default: c = $urandom_range(4095);
        endcase
        return c;
    endfunction

    // Writes all entries. A tidy table has falling codes and an end marker (or none,
    // filling the full depth); otherwise codes are arbitrary.
    task automatic build_random_table(input bit tidy);
        int          marker;
        int          code;
        int          span;
        int          dec;
        bit          rising;
        logic [15:0] temp;
        marker = $urandom_range(TABLE_DEPTH, 2);
        code   = ($urandom_range(9) == 0) ? $urandom_range(65535, 4096)
                                          : $urandom_range(4095, 64);
        span   = (code / marker > 1) ? code / marker : 1;
        temp   = 16'($urandom_range(65535));
        rising = ($urandom_range(4) != 0);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!tidy)
            begin
                code = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4095);
                send_request(load_req(i, code, $urandom_range(65535)));
            end
            else if (i < marker)
            begin
                if (i > 0)
                begin
                    // occasionally repeat entry 0's code to get a zero code step
                    dec = (i == 1 && $urandom_range(7) == 0) ? 0 : $urandom_range(span, 1);
                    if (dec >= code)
                        dec = code - 1;
                    code = code - dec;
                    temp = rising ? temp + 16'($urandom_range(3000))
                                  : temp - 16'($urandom_range(3000));
                end
                send_request(load_req(i, code, temp));
            end
            else if (i == marker)
                send_request(load_req(i, 0, $urandom_range(65535)));
            else
                send_request(load_req(i, $urandom_range(65535), $urandom_range(65535)));
        end
    endtask

    // Interpolation on a short table: extrapolation above entry 0, each segment,
    // negative and zero slopes, exact breakpoint codes, and running off the end.
    task automatic test_basic_interpolation();
        send_request(load_req(0, 3000, 100));
        send_request(load_req(1, 2300, 5100));
        send_request(load_req(2, 1500, 4000));
        send_request(load_req(3, 500, 4000));
        send_request(load_req(4, 0, 0));
        send_request(convert_req(4095, 0));
        send_request(convert_req(2700, 1));
        send_request(convert_req(2300, 2));
        send_request(convert_req(1000, 3));
        send_request(convert_req(501, 0));
        send_request(convert_req(500, 1));
        send_request(convert_req(0, 2));
        wait_drain();
    endtask

    // Entry 1 with the same code as entry 0: no division, flagged out of range.
    task automatic test_zero_code_step();
        send_request(load_req(0, 2000, 100));
        send_request(load_req(1, 2000, 900));
        send_request(load_req(2, 0, 0));
        send_request(convert_req(2001, 3));
        send_request(convert_req(4095, 2));
        send_request(convert_req(1500, 1));
        wait_drain();
    endtask

    // Full-scale code and temperature in entry 0.
    task automatic test_field_extremes();
        send_request(load_req(0, 65535, 65535));
        send_request(load_req(1, 4094, 0));
        send_request(load_req(2, 0, 65535));
        send_request(convert_req(4095, 3));
        send_request(convert_req(4094, 0));
        send_request(convert_req(0, 1));
        wait_drain();
    endtask

    // No end marker: the walk stops at the last entry, matched or not.
    task automatic test_full_depth();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(load_req(i, 4000 - i * 100, i * 64));
        send_request(convert_req(800, 0));
        send_request(convert_req(950, 1));
        send_request(convert_req(4095, 2));
        send_request(convert_req(2450, 3));
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while converts keep coming, so the
    // result path fills and the block has to stall its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        res_stall_pct = 0;
        build_random_table(1'b1);
        hold_target <= hold_target + 400;
        for (int j = 0; j < 14; j++)
            send_request(convert_req(pick_sample(), $urandom_range(3)));
        wait_drain();
    endtask

    // Mostly tidy tables, with random samples and stray entry rewrites mixed in.
    task automatic test_random_traffic(input int sets, input int idle_pct, input int stall_pct);
        int n;
        send_idle_pct = idle_pct;
        res_stall_pct = stall_pct;
        for (int s = 0; s < sets; s++)
        begin
            build_random_table($urandom_range(4) != 0);
            n = $urandom_range(24, 8);
            for (int j = 0; j < n; j++)
            begin
                if ($urandom_range(9) == 0)
                    send_request(load_req($urandom_range(TABLE_DEPTH - 1),
                                          ($urandom_range(1) != 0) ? $urandom_range(4095)
                                                                   : $urandom_range(65535),
                                          $urandom_range(65535)));
                send_request(convert_req(pick_sample(), $urandom_range(3)));
            end
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_interpolation();
        test_zero_code_step();
        test_field_extremes();
        test_full_depth();
        test_backpressure();
        test_random_traffic(7, 0, 0);
        test_random_traffic(6, 71, 0);
        test_random_traffic(6, 0, 71);
        test_random_traffic(7, 21, 21);

        send_idle_pct = 0;
        res_stall_pct = 0;
        wait_drain();
        // let any stray result show up before the verdict
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && temps_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
